### design/sliding_window_arq_sender_core_defines.svh
// Assertion macros shared by the sender core.
// They expect signals named clock and reset in the module that uses them.
`ifndef SLIDING_WINDOW_ARQ_SENDER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_ARQ_SENDER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SWARQ_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that, once seen, forces another one in the following cycle.
`define SWARQ_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### design/swarq_pkg.sv
`default_nettype none

package swarq_pkg;

   // Fixed geometry of the window and of the words.
   localparam int unsigned WINDOW_MAX = 16;
   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned SEQ_W      = 32;
   localparam int unsigned LEN_W      = 11;
   localparam int unsigned FLIGHT_W   = 5;
   localparam int unsigned KIND_W     = 3;
   localparam int unsigned OPCODE_W   = 2;
   localparam int unsigned CSR_DATA_W = 5;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [LEN_W-1:0]    PAYLOAD_MAX = 11'd1024;
   localparam logic [FLIGHT_W-1:0] WINDOW_LIM  = 5'd16;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_OFFER   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ACK     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TIMEOUT = 2'd2;

   // Response kinds.
   localparam logic [KIND_W-1:0] KIND_SEND      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RESEND    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REFUSED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ACK_TAKEN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ACK_IGNOR = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NOTHING   = 3'd5;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELECTIVE = 1'd1;

   // Commands broadcast along the chain of cells.
   typedef enum logic [2:0] {
      CMD_HOLD   = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_MARK   = 3'd2,
      CMD_SHIFT  = 3'd3,
      CMD_ROTATE = 3'd4
   } chain_cmd_type;

   // One outstanding segment, held by one cell.
   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic             acked;
   } entry_type;

   typedef struct packed {
      chain_cmd_type       cmd;
      logic [SLOT_W-1:0]   index;
      logic [LEN_W-1:0]    length;
      logic [FLIGHT_W-1:0] count;
      logic                selective;
   } chain_ctrl_type;

   typedef struct packed {
      entry_type head;
      logic      rest_pending;
   } chain_status_type;

endpackage

`default_nettype wire

### design/swarq_ifs.sv
`default_nettype none

// Request channel: one word is an offer, an acknowledgement or a timeout.
interface swarq_req_if;
   logic                                valid;
   logic                                ready;
   logic [swarq_pkg::OPCODE_W-1:0]      opcode;
   logic [swarq_pkg::LEN_W-1:0]         segment_length;
   logic [swarq_pkg::SEQ_W-1:0]         ack_seq;

   modport source (output valid, output opcode, output segment_length, output ack_seq,
                   input ready);
   modport sink (input valid, input opcode, input segment_length, input ack_seq,
                 output ready);
endinterface

// Response channel: one word per send, resend or status report.
interface swarq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [swarq_pkg::KIND_W-1:0]        kind;
   logic [swarq_pkg::SEQ_W-1:0]         seq_num;
   logic [swarq_pkg::SLOT_W-1:0]        slot;
   logic [swarq_pkg::LEN_W-1:0]         seg_length;
   logic                                last;
   logic [swarq_pkg::FLIGHT_W-1:0]      in_flight;

   modport source (output valid, output kind, output seq_num, output slot,
                   output seg_length, output last, output in_flight, input ready);
   modport sink (input valid, input kind, input seq_num, input slot,
                 input seg_length, input last, input in_flight, output ready);
endinterface

`default_nettype wire

### design/sliding_window_arq_sender_core.sv
// Offer, ignored ack, empty timeout: the request is latched in idle and decoded, then the
// response word is registered. Taken ack: the base slides one slot per step in the slide
// state, then the response word is registered. Timeout: the scan state takes one rotation
// step per outstanding segment, resending the head if due. A new request is taken only in
// idle, once the previous one is done; a stalled response output holds the sequencer.
// Synchronous active-high reset clears base, counts, acked flags and output valid.
`default_nettype none

module sliding_window_arq_sender_core (
   input  wire                                  clock,
   input  wire                                  reset,
   swarq_req_if.sink                            req_bus,
   swarq_rsp_if.source                          rsp_bus,
   input  wire                                  csr_write_enable,
   input  wire [swarq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [swarq_pkg::CSR_DATA_W-1:0]      csr_write_data
);

`include "sliding_window_arq_sender_core_defines.svh"

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECODE = 4'b0010,
      ST_SLIDE  = 4'b0100,
      ST_SCAN   = 4'b1000
   } state_type;

   localparam int unsigned SEQ_W    = swarq_pkg::SEQ_W;
   localparam int unsigned LEN_W    = swarq_pkg::LEN_W;
   localparam int unsigned FLIGHT_W = swarq_pkg::FLIGHT_W;
   localparam int unsigned SLOT_W   = swarq_pkg::SLOT_W;
   localparam int unsigned KIND_W   = swarq_pkg::KIND_W;

   state_type                         state_ff, state_in;
   logic [SEQ_W-1:0]                  base_ff, base_in;
   logic [FLIGHT_W-1:0]               flight_ff, flight_in;
   logic [FLIGHT_W-1:0]               cnt_ff, cnt_in;
   logic [SEQ_W-1:0]                  scan_seq_ff, scan_seq_in;
   logic [swarq_pkg::CSR_DATA_W-1:0]  win_ff, win_in;
   logic                              sel_ff, sel_in;
   logic [swarq_pkg::OPCODE_W-1:0]    op_ff, op_in;
   logic [LEN_W-1:0]                  len_ff, len_in;
   logic [SEQ_W-1:0]                  ack_ff, ack_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]                 kind_ff, kind_in;
   logic [SEQ_W-1:0]                  seq_ff, seq_in;
   logic [SLOT_W-1:0]                 slot_ff, slot_in;
   logic [LEN_W-1:0]                  seg_len_ff, seg_len_in;
   logic                              last_ff, last_in;
   logic [FLIGHT_W-1:0]               flight_out_ff, flight_out_in;

   swarq_pkg::chain_ctrl_type         ctrl;
   swarq_pkg::chain_status_type       status;

   logic                              out_free;
   logic                              load_out;
   logic [FLIGHT_W-1:0]               eff_win;
   logic [SEQ_W-1:0]                  next_seq;
   logic [SEQ_W-1:0]                  ack_dist;
   logic [LEN_W-1:0]                  sat_len;
   logic                              cum_ok;
   logic                              sel_ok;
   logic                              head_due;
   logic [FLIGHT_W-1:0]               flight_minus_one;
   logic                              req_taken;
   logic                              cum_slide;
   logic                              in_scan;

   swarq_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status)
   );

   // Derived values used while decoding a request.
   always_comb begin
      if (win_ff == '0) begin
         eff_win = FLIGHT_W'(1);
      end else if (win_ff > swarq_pkg::WINDOW_LIM) begin
         eff_win = swarq_pkg::WINDOW_LIM;
      end else begin
         eff_win = win_ff;
      end
   end

   assign next_seq         = base_ff + {{(SEQ_W-FLIGHT_W){1'b0}}, flight_ff};
   assign ack_dist         = ack_ff - base_ff;
   assign sat_len          = (len_ff > swarq_pkg::PAYLOAD_MAX) ? swarq_pkg::PAYLOAD_MAX : len_ff;
   assign cum_ok           = (ack_dist != '0) &&
                             (ack_dist <= {{(SEQ_W-FLIGHT_W){1'b0}}, flight_ff});
   assign sel_ok           = ack_dist < {{(SEQ_W-FLIGHT_W){1'b0}}, flight_ff};
   assign head_due         = !sel_ff || !status.head.acked;
   assign flight_minus_one = flight_ff - FLIGHT_W'(1);
   assign out_free         = !rsp_valid_ff || rsp_bus.ready;

   // Control sequencer: decode, slide the base, or sweep outstanding cells.
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      flight_in     = flight_ff;
      cnt_in        = cnt_ff;
      scan_seq_in   = scan_seq_ff;
      op_in         = op_ff;
      len_in        = len_ff;
      ack_in        = ack_ff;
      load_out      = 1'b0;
      kind_in       = kind_ff;
      seq_in        = '0;
      slot_in       = '0;
      seg_len_in    = '0;
      last_in       = 1'b1;
      flight_out_in = flight_ff;

      ctrl.cmd       = swarq_pkg::CMD_HOLD;
      ctrl.index     = '0;
      ctrl.length    = sat_len;
      ctrl.count     = cnt_ff;
      ctrl.selective = sel_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.opcode;
               len_in   = req_bus.segment_length;
               ack_in   = req_bus.ack_seq;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (op_ff)
               swarq_pkg::OP_OFFER: begin
                  if (out_free) begin
                     load_out = 1'b1;
                     state_in = ST_IDLE;
                     if (flight_ff >= eff_win) begin
                        kind_in = swarq_pkg::KIND_REFUSED;
                     end else begin
                        ctrl.cmd      = swarq_pkg::CMD_WRITE;
                        ctrl.index    = flight_ff[SLOT_W-1:0];
                        flight_in     = flight_ff + FLIGHT_W'(1);
                        kind_in       = swarq_pkg::KIND_SEND;
                        seq_in        = next_seq;
                        slot_in       = next_seq[SLOT_W-1:0];
                        seg_len_in    = sat_len;
                        flight_out_in = flight_ff + FLIGHT_W'(1);
                     end
                  end
               end
               swarq_pkg::OP_ACK: begin
                  if (sel_ff ? sel_ok : cum_ok) begin
                     if (sel_ff) begin
                        ctrl.cmd   = swarq_pkg::CMD_MARK;
                        ctrl.index = ack_dist[SLOT_W-1:0];
                     end
                     cnt_in   = ack_dist[FLIGHT_W-1:0];
                     state_in = ST_SLIDE;
                  end else if (out_free) begin
                     load_out = 1'b1;
                     kind_in  = swarq_pkg::KIND_ACK_IGNOR;
                     state_in = ST_IDLE;
                  end
               end
               swarq_pkg::OP_TIMEOUT: begin
                  if (flight_ff == '0) begin
                     if (out_free) begin
                        load_out = 1'b1;
                        kind_in  = swarq_pkg::KIND_NOTHING;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     cnt_in      = flight_ff;
                     scan_seq_in = base_ff;
                     state_in    = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SLIDE: begin
            // Cumulative: move by a counted distance. Selective: over the acked run.
            if (sel_ff ? ((flight_ff != '0) && status.head.acked) : (cnt_ff != '0)) begin
               ctrl.cmd  = swarq_pkg::CMD_SHIFT;
               base_in   = base_ff + SEQ_W'(1);
               flight_in = flight_ff - FLIGHT_W'(1);
               cnt_in    = cnt_ff - FLIGHT_W'(1);
            end else if (out_free) begin
               load_out = 1'b1;
               kind_in  = swarq_pkg::KIND_ACK_TAKEN;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // Each step rotates the outstanding cells once, resending the head if due.
            if (!head_due || out_free) begin
               ctrl.cmd    = swarq_pkg::CMD_ROTATE;
               ctrl.index  = flight_minus_one[SLOT_W-1:0];
               scan_seq_in = scan_seq_ff + SEQ_W'(1);
               cnt_in      = cnt_ff - FLIGHT_W'(1);
               if (head_due) begin
                  load_out   = 1'b1;
                  kind_in    = swarq_pkg::KIND_RESEND;
                  seq_in     = scan_seq_ff;
                  slot_in    = scan_seq_ff[SLOT_W-1:0];
                  seg_len_in = status.head.length;
                  last_in    = !status.rest_pending;
               end
               if (cnt_ff == FLIGHT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      win_in = win_ff;
      sel_in = sel_ff;
      if (csr_write_enable) begin
         case (csr_index)
            swarq_pkg::CSR_WINDOW:    win_in = csr_write_data;
            swarq_pkg::CSR_SELECTIVE: sel_in = csr_write_data[0];
            default: begin
               win_in = win_ff;
               sel_in = sel_ff;
            end
         endcase
      end
   end

   // The output word register frees the control path from the response side.
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         flight_ff    <= '0;
         cnt_ff       <= '0;
         win_ff       <= swarq_pkg::CSR_DATA_W'(8);
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         flight_ff    <= flight_in;
         cnt_ff       <= cnt_in;
         win_ff       <= win_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_seq_ff <= scan_seq_in;
      op_ff       <= op_in;
      len_ff      <= len_in;
      ack_ff      <= ack_in;
      if (load_out) begin
         kind_ff       <= kind_in;
         seq_ff        <= seq_in;
         slot_ff       <= slot_in;
         seg_len_ff    <= seg_len_in;
         last_ff       <= last_in;
         flight_out_ff <= flight_out_in;
      end
   end

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.kind       = kind_ff;
   assign rsp_bus.seq_num    = seq_ff;
   assign rsp_bus.slot       = slot_ff;
   assign rsp_bus.seg_length = seg_len_ff;
   assign rsp_bus.last       = last_ff;
   assign rsp_bus.in_flight  = flight_out_ff;

   // Checks on the sequencer.
   assign req_taken = req_bus.valid && req_bus.ready;
   assign cum_slide = (state_ff == ST_SLIDE) && !sel_ff;
   assign in_scan   = (state_ff == ST_SCAN);

   `SWARQ_ASSERT_ALWAYS(a_flight_bound, flight_ff <= swarq_pkg::WINDOW_LIM, "flight over depth")
   `SWARQ_ASSERT_NEXT(a_accept_leaves_idle, req_taken, state_ff == ST_DECODE, "not decoded")
   `SWARQ_ASSERT_ALWAYS(a_slide_count, !cum_slide || (cnt_ff <= flight_ff), "slide too far")
   `SWARQ_ASSERT_ALWAYS(a_scan_count, !in_scan || (cnt_ff != '0), "empty sweep count")
   `SWARQ_ASSERT_ALWAYS(a_scan_bound, !in_scan || (cnt_ff <= flight_ff), "sweep count too big")

endmodule

`default_nettype wire

### design/swarq_cell.sv
`default_nettype none

// One window position, holding the segment at a fixed offset from the base.
module swarq_cell (
   input  wire                             clock,
   input  wire                             reset,
   input  wire [swarq_pkg::SLOT_W-1:0]     cell_index,
   input  swarq_pkg::chain_ctrl_type       ctrl,
   input  swarq_pkg::entry_type            right,
   input  swarq_pkg::entry_type            head,
   output swarq_pkg::entry_type            entry,
   output logic                            pending
);

   logic [swarq_pkg::LEN_W-1:0] length_ff;
   logic [swarq_pkg::LEN_W-1:0] length_in;
   logic                        acked_ff;
   logic                        acked_in;

   // Next contents: local write, mark, shift towards the base, or rotation.
   always_comb begin
      length_in = length_ff;
      acked_in  = acked_ff;
      case (ctrl.cmd)
         swarq_pkg::CMD_WRITE: begin
            if (cell_index == ctrl.index) begin
               length_in = ctrl.length;
               acked_in  = 1'b0;
            end
         end
         swarq_pkg::CMD_MARK: begin
            if (cell_index == ctrl.index) begin
               acked_in = 1'b1;
            end
         end
         swarq_pkg::CMD_SHIFT: begin
            length_in = right.length;
            acked_in  = right.acked;
         end
         swarq_pkg::CMD_ROTATE: begin
            if (cell_index == ctrl.index) begin
               length_in = head.length;
               acked_in  = head.acked;
            end else if (cell_index < ctrl.index) begin
               length_in = right.length;
               acked_in  = right.acked;
            end
         end
         default: begin
            length_in = length_ff;
            acked_in  = acked_ff;
         end
      endcase
   end

   // The acked flag is control state; the length is plain payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         acked_ff <= 1'b0;
      end else begin
         acked_ff <= acked_in;
      end
   end

   always_ff @(posedge clock) begin
      length_ff <= length_in;
   end

   assign entry.length = length_ff;
   assign entry.acked  = acked_ff;

   // Still due for a resend within the remaining part of a timeout sweep.
   assign pending = ({1'b0, cell_index} < ctrl.count) && (!ctrl.selective || !acked_ff);

endmodule

`default_nettype wire

### design/swarq_chain.sv
`default_nettype none

// Row of cells ordered by offset from the window base; cell 0 is the base.
module swarq_chain (
   input  wire                         clock,
   input  wire                         reset,
   input  swarq_pkg::chain_ctrl_type   ctrl,
   output swarq_pkg::chain_status_type status
);

   swarq_pkg::entry_type                entries [swarq_pkg::WINDOW_MAX];
   logic [swarq_pkg::WINDOW_MAX-1:0]    pending;

   for (genvar i = 0; i < swarq_pkg::WINDOW_MAX; i++) begin : g_cell
      localparam logic [31:0] CELL_POS = i;
      swarq_pkg::entry_type right;

      // The last cell is refilled with an empty entry when the row shifts.
      if (i == swarq_pkg::WINDOW_MAX - 1) begin : g_tail
         assign right = swarq_pkg::entry_type'{length: '0, acked: 1'b0};
      end else begin : g_body
         assign right = entries[i+1];
      end

      swarq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CELL_POS[swarq_pkg::SLOT_W-1:0]),
         .ctrl       (ctrl),
         .right      (right),
         .head       (entries[0]),
         .entry      (entries[i]),
         .pending    (pending[i])
      );
   end

   // The head feeds the response path; the rest tells whether it is the last resend.
   assign status.head         = entries[0];
   assign status.rest_pending = |pending[swarq_pkg::WINDOW_MAX-1:1];

endmodule

`default_nettype wire
